FILE: hdl/at_rlc_pkg.sv
package at_rlc_pkg;

    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_SP       = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_E        = 8'h45;
    localparam logic [7:0] CH_R        = 8'h52;
    localparam logic [7:0] CH_O        = 8'h4F;
    localparam logic [7:0] CH_K        = 8'h4B;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_9        = 8'h39;

    // Length of the pattern "ERROR".
    localparam logic [2:0] ERR_LEN = 3'd5;

    localparam logic [31:0] ACC_MAX = 32'hFFFF_FFFF;

    // Width of the packed result on the output stream, padded to bytes.
    localparam int RES_W  = 35;
    localparam int RES_TW = 40;

    typedef enum logic [1:0] {
        OKP_EMPTY = 2'd0,
        OKP_O     = 2'd1,
        OKP_OK    = 2'd2,
        OKP_NONE  = 2'd3
    } okp_t;

    typedef struct packed {
        okp_t        ok_prog;
        logic        digits_only;
        logic        nonempty;
        logic [31:0] accum;
        logic [2:0]  err_prog;
        logic        err_found;
    } tok_state_t;

    localparam tok_state_t TOK_INIT = '{
        ok_prog:     OKP_EMPTY,
        digits_only: 1'b1,
        nonempty:    1'b0,
        accum:       32'd0,
        err_prog:    3'd0,
        err_found:   1'b0
    };

    typedef struct packed {
        logic [31:0] number;
        logic        value_valid;
        logic        error_seen;
        logic        ok_reply;
    } result_t;

    // Character expected at each position of "ERROR".
    function automatic logic [7:0] err_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = CH_E;
            3'd1:    ch = CH_R;
            3'd2:    ch = CH_R;
            3'd3:    ch = CH_O;
            3'd4:    ch = CH_R;
            default: ch = CH_E;
        endcase
        return ch;
    endfunction

endpackage

FILE: hdl/at_rlc_line_track.sv
module at_rlc_line_track (
    input  logic [7:0]              byte_in,
    input  logic                    keep,
    input  logic                    line_empty,
    input  at_rlc_pkg::tok_state_t  tok_cur,
    output at_rlc_pkg::tok_state_t  tok_nxt,
    output logic                    is_eol,
    output logic                    emit,
    output at_rlc_pkg::result_t     res
);
    import at_rlc_pkg::*;

    logic [2:0]  err_pos;
    logic        is_delim;
    logic        is_digit;
    logic [35:0] acc_prod;
    logic        valid;

    assign is_eol   = (byte_in == CH_CR) || (byte_in == CH_LF);
    assign emit     = is_eol && !line_empty;
    assign is_delim = (byte_in == CH_SP) || (byte_in == CH_TAB) || (byte_in == CH_RBRACKET);
    assign is_digit = (byte_in >= CH_0) && (byte_in <= CH_9);
    assign err_pos  = (tok_cur.err_prog >= ERR_LEN) ? 3'd0 : tok_cur.err_prog;

    // accum * 10 + digit, with headroom to detect overflow.
    assign acc_prod = {1'b0, tok_cur.accum, 3'b000} + {3'b000, tok_cur.accum, 1'b0}
                    + {32'd0, byte_in[3:0] - CH_0[3:0]};

    assign valid           = tok_cur.digits_only && tok_cur.nonempty;
    assign res.ok_reply    = (tok_cur.ok_prog == OKP_OK);
    assign res.error_seen  = tok_cur.err_found;
    assign res.value_valid = valid;
    assign res.number      = valid ? tok_cur.accum : 32'd0;

    always_comb
    begin
        tok_nxt = tok_cur;
        if (is_eol)
        begin
            tok_nxt = TOK_INIT;
        end
        else if (keep)
        begin
            // Search for "ERROR"; it has no self-overlap, so a miss restarts.
            if (byte_in == err_char(err_pos))
            begin
                if (err_pos + 3'd1 == ERR_LEN)
                begin
                    tok_nxt.err_found = 1'b1;
                    tok_nxt.err_prog  = 3'd0;
                end
                else
                begin
                    tok_nxt.err_prog = err_pos + 3'd1;
                end
            end
            else
            begin
                tok_nxt.err_prog = (byte_in == CH_E) ? 3'd1 : 3'd0;
            end

            if (is_delim)
            begin
                tok_nxt.ok_prog     = OKP_EMPTY;
                tok_nxt.digits_only = 1'b1;
                tok_nxt.nonempty    = 1'b0;
                tok_nxt.accum       = 32'd0;
            end
            else
            begin
                tok_nxt.nonempty = 1'b1;
                if (tok_cur.ok_prog == OKP_EMPTY && byte_in == CH_O)
                    tok_nxt.ok_prog = OKP_O;
                else if (tok_cur.ok_prog == OKP_O && byte_in == CH_K)
                    tok_nxt.ok_prog = OKP_OK;
                else
                    tok_nxt.ok_prog = OKP_NONE;

                if (is_digit)
                begin
                    if (tok_cur.digits_only)
                        tok_nxt.accum = (acc_prod[35:32] != 4'd0) ? ACC_MAX : acc_prod[31:0];
                end
                else
                begin
                    tok_nxt.digits_only = 1'b0;
                    tok_nxt.accum       = 32'd0;
                end
            end
        end
    end

endmodule

FILE: hdl/at_response_line_classifier.sv
// The line end passes the input register, and its result is then held in the result register.
// Throughput: one byte per cycle while no line end waits on the result register, set by the
// line state update loop (token, "OK" and "ERROR" trackers plus the times-ten accumulator).
// Reset: rst_n is asynchronous and active low; it empties both pipeline registers and
// returns all line state to the empty-line condition.
module at_response_line_classifier #(
    parameter int LINE_CAPACITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [0] ok_reply, [1] error_seen, [2] value_valid,
                                        // [34:3] number, [39:35] zero
);
    import at_rlc_pkg::*;

    // The kept counter only has to reach LINE_CAPACITY-1.
    localparam int KEPT_W = $clog2(LINE_CAPACITY);
    localparam logic [KEPT_W-1:0] KEPT_MAX = KEPT_W'(LINE_CAPACITY - 1);

    // Input register: holds one byte that has been transferred in but not yet processed.
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;

    // Line state.
    logic [KEPT_W-1:0] kept_reg;
    logic [KEPT_W-1:0] kept_next;
    tok_state_t        tok_reg;
    tok_state_t        tok_next;

    // Result register.
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_data_reg;

    logic              is_eol;
    logic              emit;
    result_t           res;
    logic              keep;
    logic              out_free;
    logic              advance;

    assign keep = (kept_reg < KEPT_MAX);

    at_rlc_line_track u_track (
        .byte_in    (in_byte_reg),
        .keep       (keep),
        .line_empty (kept_reg == '0),
        .tok_cur    (tok_reg),
        .tok_nxt    (tok_next),
        .is_eol     (is_eol),
        .emit       (emit),
        .res        (res)
    );

    // A byte that produces no result can always be processed; a line end with
    // kept text waits until the result register is free or being emptied.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!emit || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        if (is_eol)
            kept_next = '0;
        else if (keep)
            kept_next = kept_reg + KEPT_W'(1);
        else
            kept_next = kept_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (advance && emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            kept_reg      <= '0;
            tok_reg       <= TOK_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
            begin
                kept_reg <= kept_next;
                tok_reg  <= tok_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
        if (advance && emit)
            out_data_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(RES_TW - RES_W)'(0), out_data_reg};

endmodule

FILE: hdl/at_rlc_checker.sv
module at_rlc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // With no result waiting, nothing can hold back the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no result waiting");

    // A number is only reported together with a valid flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2] || m_axis_tdata[34:3] == 32'd0))
        else $error("nonzero number without value_valid");

    // A token cannot be both "OK" and all digits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[2]))
        else $error("ok_reply and value_valid both set");

    // Padding bits above the result are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:35] == 5'd0))
        else $error("padding bits set in result");

endmodule

bind at_response_line_classifier at_rlc_checker u_at_rlc_checker (.*);
